### rtl/core/fec_pkg.sv
// Shared types, constants and helpers of the coalescing free extent table.
// Used by the extent cells, the walk unit, the top level and the port checker.
package fec_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int STEP_W      = $clog2(MAX_EXTENTS + 2);

    localparam logic [0:0] CFG_HEADER_BYTES = 1'd0;
    localparam logic [0:0] CFG_HEAP_TOTAL   = 1'd1;

    localparam logic [7:0]  HEADER_RESET = 8'd16;
    localparam logic [31:0] HEAP_RESET   = 32'd0;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] payload;
    } extent_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
        logic [7:0]  hdr;
        logic [31:0] addr_m;
        logic        addr_ok;
        logic [33:0] blk_end;
        logic [32:0] sz_h;
        logic [CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic              run;
        logic              first;
        logic [STEP_W-1:0] step;
    } walk_ctl_t;

    typedef struct packed {
        logic mb;
        logic ma;
    } walk_res_t;

    typedef struct packed {
        logic        accepted;
        logic        merged_before;
        logic        merged_after;
        logic [6:0]  free_extent_count;
        logic [31:0] free_bytes;
        logic [31:0] heap_total;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MD_SEEK,
        MD_PASS,
        MD_SKIP,
        MD_REPLACE,
        MD_INSERT,
        MD_SHIFT
    } mode_t;

    function automatic logic [31:0] sat32(input logic [34:0] v);
        logic [31:0] r;
        r = (|v[34:32]) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

### rtl/core/fec_if.sv
// Valid/ready channel interfaces for freed blocks and for result items.
// Depends on nothing but the field widths of the block.
interface fec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [31:0] block_size;

    modport source (output valid, block_address, block_size, input ready);
    modport sink   (input valid, block_address, block_size, output ready);
endinterface

interface fec_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        merged_before;
    logic        merged_after;
    logic [6:0]  free_extent_count;
    logic [31:0] free_bytes;
    logic [31:0] heap_total;

    modport source (output valid, accepted, merged_before, merged_after, free_extent_count,
                    free_bytes, heap_total, input ready);
    modport sink   (input valid, accepted, merged_before, merged_after, free_extent_count,
                    free_bytes, heap_total, output ready);
endinterface

### rtl/core/fec_cell.sv
// One storage cell of the extent chain: holds one extent and loads its neighbor on shift.
// Depends on fec_pkg.
module fec_cell
(
    input  logic            clk,
    input  logic            shift,
    input  fec_pkg::extent_t nbr,
    output fec_pkg::extent_t held
);

    fec_pkg::extent_t ext_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ext_reg <= nbr;
        end
    end

    assign held = ext_reg;

endmodule

### rtl/core/fec_walk.sv
// Walk unit: reads the head cell of the rotating chain and writes the rewritten
// stream into the tail cell, behind its stage registers s1_reg and s2_reg. Depends on fec_pkg.
module fec_walk
(
    input  logic               clk,
    input  logic               rst_n,
    input  fec_pkg::walk_ctl_t ctl,
    input  fec_pkg::job_t      job,
    input  fec_pkg::extent_t   head,
    output fec_pkg::extent_t   tail,
    output fec_pkg::walk_res_t res
);

    typedef struct packed {
        fec_pkg::extent_t e;
        logic             on;
        logic             valid;
        logic             le;
        logic             mbf;
        logic             maf;
        logic [33:0]      psum;
        logic [32:0]      t;
    } stage_t;

    stage_t s1_reg, s1_next, s2_reg;
    fec_pkg::extent_t d_reg;
    fec_pkg::mode_t mode_reg, mode_next;
    logic mb_reg, mb_next, ma_reg, ma_next;
    logic [34:0] both_sum;

    always_comb
    begin
        s1_next.e     = head;
        s1_next.on    = ctl.step < fec_pkg::STEP_W'(fec_pkg::MAX_EXTENTS);
        s1_next.valid = ctl.step < fec_pkg::STEP_W'(job.count);
        s1_next.le    = head.start <= job.addr;
        s1_next.mbf   = job.addr_ok &&
                        (({1'b0, head.start} + {1'b0, head.payload}) == {1'b0, job.addr_m});
        s1_next.maf   = {2'b00, head.start} == job.blk_end;
        s1_next.psum  = {2'b00, head.payload} + {1'b0, job.sz_h};
        s1_next.t     = {1'b0, head.payload} + {25'd0, job.hdr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            mode_reg <= fec_pkg::MD_SEEK;
            mb_reg   <= 1'b0;
            ma_reg   <= 1'b0;
        end
        else if (ctl.first)
        begin
            mode_reg <= fec_pkg::MD_SEEK;
            mb_reg   <= 1'b0;
            ma_reg   <= 1'b0;
        end
        else if (ctl.run)
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            mode_reg <= mode_next;
            mb_reg   <= mb_next;
            ma_reg   <= ma_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.run)
        begin
            d_reg <= s2_reg.e;
        end
    end

    assign both_sum = {1'b0, s2_reg.psum} + {2'b00, s1_reg.t};

    always_comb
    begin
        tail      = s2_reg.e;
        mode_next = mode_reg;
        mb_next   = mb_reg;
        ma_next   = ma_reg;
        if (s2_reg.on)
        begin
            unique case (mode_reg)
                fec_pkg::MD_SEEK:
                begin
                    if (s2_reg.valid && s2_reg.le)
                    begin
                        if (!(s1_reg.valid && s1_reg.le))
                        begin
                            mb_next = s2_reg.mbf;
                            ma_next = s1_reg.valid && s1_reg.maf;
                            if (s2_reg.mbf && ma_next)
                            begin
                                tail.payload = fec_pkg::sat32(both_sum);
                                mode_next    = fec_pkg::MD_SKIP;
                            end
                            else if (s2_reg.mbf)
                            begin
                                tail.payload = fec_pkg::sat32({1'b0, s2_reg.psum});
                                mode_next    = fec_pkg::MD_PASS;
                            end
                            else if (ma_next)
                            begin
                                mode_next = fec_pkg::MD_REPLACE;
                            end
                            else
                            begin
                                mode_next = fec_pkg::MD_INSERT;
                            end
                        end
                    end
                    else
                    begin
                        mb_next = 1'b0;
                        ma_next = s2_reg.valid && s2_reg.maf;
                        tail.start = job.addr;
                        if (ma_next)
                        begin
                            tail.payload = fec_pkg::sat32({1'b0, s2_reg.psum});
                            mode_next    = fec_pkg::MD_PASS;
                        end
                        else
                        begin
                            tail.payload = job.size;
                            mode_next    = fec_pkg::MD_SHIFT;
                        end
                    end
                end
                fec_pkg::MD_REPLACE:
                begin
                    tail.start   = job.addr;
                    tail.payload = fec_pkg::sat32({1'b0, s2_reg.psum});
                    mode_next    = fec_pkg::MD_PASS;
                end
                fec_pkg::MD_INSERT:
                begin
                    tail.start   = job.addr;
                    tail.payload = job.size;
                    mode_next    = fec_pkg::MD_SHIFT;
                end
                fec_pkg::MD_SHIFT:
                begin
                    tail = d_reg;
                end
                fec_pkg::MD_SKIP:
                begin
                    tail = s1_reg.e;
                end
                fec_pkg::MD_PASS:
                begin
                    tail = s2_reg.e;
                end
                default:
                begin
                    tail = s2_reg.e;
                end
            endcase
        end
    end

    assign res.mb = mb_reg;
    assign res.ma = ma_reg;

endmodule

### rtl/core/coalescing_free_extent_table_unit.sv
// Top level of the coalescing free extent table: control, totals, result register.
// Depends on fec_pkg, fec_if, fec_cell and fec_walk.
//
// Usage:
//   in_ch carries one freed block per item (block_address, block_size), valid/ready.
//   out_ch carries one result item per freed block, valid/ready, held in an
//   output register until taken.
//   cfg_we/cfg_index/cfg_data write header_bytes (index 0) or heap_total_bytes
//   (index 1); write only while no item is in flight.
// Timing:
//   The extents live in a chain of MAX_EXTENTS cells that rotates by one cell
//   per cycle while an item walks. An item rotates the whole chain once and passes
//   through the walk unit pipeline, then its result is posted from ST_DONE.
//   An accepted item gives its result once the walk ends and out_ch is free; a block
//   that finds the table full skips the walk and goes straight to ST_DONE.
//   One item is in work at a time (ready only when idle).
// Reset:
//   Clears the extent count and the free byte total, sets header_bytes to 16
//   and heap_total_bytes to 0. The cells themselves are not cleared.
// Stall:
//   A result waits in the output register; a finished walk holds in its last
//   state and input stays blocked until the waiting result is taken.
module coalescing_free_extent_table_unit
(
    input  logic            clk,
    input  logic            rst_n,
    fec_in_if.sink          in_ch,
    fec_out_if.source       out_ch,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [31:0]     cfg_data
);

    fec_pkg::state_t state_reg, state_next;
    logic [fec_pkg::STEP_W-1:0] step_reg, step_next;
    fec_pkg::job_t job_reg, job_next;
    logic acc_reg, acc_next;
    logic [fec_pkg::CNT_W-1:0] count_reg, count_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  hdr_reg;
    logic [31:0] heap_reg;
    logic out_valid_reg, out_valid_next;
    fec_pkg::result_t res_reg, res_next;

    fec_pkg::walk_ctl_t ctl;
    fec_pkg::walk_res_t wres;
    fec_pkg::extent_t   tail;
    fec_pkg::extent_t   chain [fec_pkg::MAX_EXTENTS];

    logic in_acc;
    logic [32:0] sz_h;

    genvar gi;
    generate
        for (gi = 0; gi < fec_pkg::MAX_EXTENTS; gi++)
        begin : g_cell
            if (gi == fec_pkg::MAX_EXTENTS - 1)
            begin : g_last
                fec_cell u_cell (.clk(clk), .shift(ctl.run), .nbr(tail), .held(chain[gi]));
            end
            else
            begin : g_mid
                fec_cell u_cell (.clk(clk), .shift(ctl.run), .nbr(chain[gi+1]),
                                 .held(chain[gi]));
            end
        end
    endgenerate

    fec_walk u_walk
    (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .job  (job_reg),
        .head (chain[0]),
        .tail (tail),
        .res  (wres)
    );

    assign in_ch.ready = state_reg == fec_pkg::ST_IDLE;
    assign in_acc      = in_ch.valid && (state_reg == fec_pkg::ST_IDLE);
    assign sz_h        = {1'b0, in_ch.block_size} + {25'd0, hdr_reg};

    assign ctl.run   = state_reg == fec_pkg::ST_WALK;
    assign ctl.first = in_acc;
    assign ctl.step  = step_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        acc_next       = acc_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        unique case (state_reg)
            fec_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    job_next.addr    = in_ch.block_address;
                    job_next.size    = in_ch.block_size;
                    job_next.hdr     = hdr_reg;
                    job_next.addr_m  = in_ch.block_address - {24'd0, hdr_reg};
                    job_next.addr_ok = in_ch.block_address >= {24'd0, hdr_reg};
                    job_next.blk_end = {2'b00, in_ch.block_address} + {1'b0, sz_h};
                    job_next.sz_h    = sz_h;
                    job_next.count   = count_reg;
                    acc_next  = count_reg != fec_pkg::CNT_W'(fec_pkg::MAX_EXTENTS);
                    step_next = '0;
                    state_next = acc_next ? fec_pkg::ST_WALK : fec_pkg::ST_DONE;
                end
            end
            fec_pkg::ST_WALK:
            begin
                step_next = step_reg + fec_pkg::STEP_W'(1);
                if (step_reg == fec_pkg::STEP_W'(fec_pkg::MAX_EXTENTS + 1))
                begin
                    state_next = fec_pkg::ST_DONE;
                end
            end
            fec_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (acc_reg)
                    begin
                        if (wres.mb && wres.ma)
                        begin
                            count_next = count_reg - fec_pkg::CNT_W'(1);
                        end
                        else if (!wres.mb && !wres.ma)
                        begin
                            count_next = count_reg + fec_pkg::CNT_W'(1);
                        end
                        sum_next = fec_pkg::sat32({3'b000, sum_reg} + {2'b00, job_reg.sz_h});
                    end
                    res_next.accepted          = acc_reg;
                    res_next.merged_before     = acc_reg && wres.mb;
                    res_next.merged_after      = acc_reg && wres.ma;
                    res_next.free_extent_count = 7'(count_next);
                    res_next.free_bytes        = sum_next;
                    res_next.heap_total        = heap_reg;
                    out_valid_next = 1'b1;
                    state_next     = fec_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fec_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fec_pkg::ST_IDLE;
            step_reg      <= '0;
            acc_reg       <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg  <= fec_pkg::HEADER_RESET;
            heap_reg <= fec_pkg::HEAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fec_pkg::CFG_HEADER_BYTES: hdr_reg  <= cfg_data[7:0];
                fec_pkg::CFG_HEAP_TOTAL:   heap_reg <= cfg_data;
                default:                   hdr_reg  <= hdr_reg;
            endcase
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.accepted          = res_reg.accepted;
    assign out_ch.merged_before     = res_reg.merged_before;
    assign out_ch.merged_after      = res_reg.merged_after;
    assign out_ch.free_extent_count = res_reg.free_extent_count;
    assign out_ch.free_bytes        = res_reg.free_bytes;
    assign out_ch.heap_total        = res_reg.heap_total;

endmodule

### rtl/core/fec_checker.sv
// Port-level checks of the coalescing free extent table, bound to the top level.
// Depends on fec_pkg.
module fec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic        merged_before,
    input logic        merged_after,
    input logic [6:0]  free_extent_count,
    input logic [31:0] free_bytes
);

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while an item is in work");

    a_drop_no_merge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> !merged_before && !merged_after)
        else $error("dropped item reports a merge");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> free_extent_count <= 7'(fec_pkg::MAX_EXTENTS))
        else $error("extent count beyond table size");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(free_bytes))
        else $error("stalled result item changed");

endmodule

bind coalescing_free_extent_table_unit fec_checker u_fec_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .accepted         (out_ch.accepted),
    .merged_before    (out_ch.merged_before),
    .merged_after     (out_ch.merged_after),
    .free_extent_count(out_ch.free_extent_count),
    .free_bytes       (out_ch.free_bytes)
);
